/* rtl/fims_pkg.sv */
`default_nettype none

package fims_pkg;

    // Frame geometry and channel depth
    localparam int MAX_WIDTH    = 128;
    localparam int MAX_HEIGHT   = 128;
    localparam int CHANNEL_BITS = 16;
    localparam int NUM_CHAN     = 3;

    // Fixed field widths of the channels and registers
    localparam int FUNC_W    = 3;
    localparam int COORD_W   = 7;
    localparam int CHAN_W    = 16;
    localparam int SIZE_BITS = 8;

    // Store addressing: {row, column}
    localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
    localparam int STORE_DEPTH = MAX_HEIGHT * (2 ** COL_BITS);
    localparam int PIX_BITS    = NUM_CHAN * CHANNEL_BITS;

    localparam logic [CHAN_W-1:0] CHAN_MAX = CHAN_W'((33'd1 << CHANNEL_BITS) - 33'd1);

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Register port
    localparam int PADDR_BITS   = 4;
    localparam int PDATA_BITS   = 32;
    localparam int REG_IDX_BITS = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MAX    = 2'd2;

    localparam logic [SIZE_BITS-1:0] RST_WIDTH  = 8'd128;
    localparam logic [SIZE_BITS-1:0] RST_HEIGHT = 8'd128;
    localparam logic [CHAN_W-1:0]    RST_MAX    = 16'd255;

    // Function codes on the input channel
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INVERT = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_MROWS  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MCOLS  = 3'd4;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_READ,
        OP_INVERT,
        OP_MROWS,
        OP_MCOLS
    } t_op;

    typedef struct packed {
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
        logic [CHAN_W-1:0]    max_intensity;
    } t_cfg;

    // Classified command; sweep commands carry the geometry they were issued with
    typedef struct packed {
        t_op                  op;
        logic [ADDR_BITS-1:0] addr;
        logic                 in_img;
        logic [PIX_BITS-1:0]  pix;
        logic [SIZE_BITS-1:0] lim_o;
        logic [SIZE_BITS-1:0] lim_i;
        logic [SIZE_BITS-1:0] far;
        logic [CHAN_W-1:0]    maxv;
    } t_cmd;

    function automatic logic [ADDR_BITS-1:0] mk_addr(input logic [SIZE_BITS-1:0] r,
                                                     input logic [SIZE_BITS-1:0] c);
        return {ROW_BITS'(r), COL_BITS'(c)};
    endfunction

endpackage

`default_nettype wire

/* rtl/fims_ifs.sv */
`default_nettype none

// Pixel command channel
interface fims_pix_if;
    import fims_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;

    modport source (output valid, func, row, column, red, green, blue, input ready);
    modport sink   (input valid, func, row, column, red, green, blue, output ready);
endinterface

// Read result channel
interface fims_res_if;
    import fims_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              in_range;

    modport source (output valid, red_out, green_out, blue_out, in_range, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, in_range, output ready);
endinterface

`default_nettype wire

/* rtl/frame_invert_mirror_store.sv */
// RGB frame store of 128 x 128 pixels, 16 bits per channel, held in one single-port-write,
// single-port-read memory. A front stage checks coordinates, clamps written channels and
// drops commands that do nothing, then places the rest in a two-entry command queue; the
// back stage executes them in order. A pixel write goes straight to the memory; a read
// passes through the registered memory read, then the result register, and returns one
// result transaction, zeros with in_range low when outside the image. Invert passes over
// every pixel in use at one pixel per cycle. Mirror swaps pixel pairs through the memory's
// one read and one write port, top to bottom or left to right: it reads the near pixel,
// then its partner, and writes each to the other's place. The geometry and intensity limit
// in force when a command is accepted are the ones it uses. Stored pixels are undefined
// until written; there is no clearing pass after reset. Registers: width at 0x0, height at
// 0x4, max intensity at 0x8.
`default_nettype none

module frame_invert_mirror_store (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fims_pix_if.sink                         i_pix,
    fims_res_if.source                       o_res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fims_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [fims_pkg::PDATA_BITS-1:0]  pwdata,
    output logic [fims_pkg::PDATA_BITS-1:0]  prdata,
    output logic                             pready
);
    import fims_pkg::*;

    logic [SIZE_BITS-1:0]    r_width;
    logic [SIZE_BITS-1:0]    r_height;
    logic [CHAN_W-1:0]       r_max;
    logic [REG_IDX_BITS-1:0] reg_idx;
    t_cfg                    cfg;

    logic                    q_push;
    logic                    q_pop;
    logic                    q_empty;
    logic                    q_full;
    logic [QCNT_BITS-1:0]    q_count;
    t_cmd                    push_cmd;
    t_cmd                    head_cmd;

    // Register port
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_max    <= RST_MAX;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_WIDTH:  r_width  <= pwdata[SIZE_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[SIZE_BITS-1:0];
                REG_MAX:    r_max    <= pwdata[CHAN_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = PDATA_BITS'(r_width);
            REG_HEIGHT: prdata = PDATA_BITS'(r_height);
            REG_MAX:    prdata = PDATA_BITS'(r_max);
            default:    prdata = '0;
        endcase
    end

    assign cfg.width         = r_width;
    assign cfg.height        = r_height;
    assign cfg.max_intensity = r_max;

    // Classification, queue, execution
    fims_front u_front (
        .i_cfg    (cfg),
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    fims_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_count (q_count)
    );

    fims_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_cmd   (head_cmd),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

    // Out-of-range reads carry zero channels
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.in_range) |->
            (o_res.red_out == '0 && o_res.green_out == '0 && o_res.blue_out == '0))
        else $error("out-of-range read result has nonzero channels");

    // Queue never holds more than its depth, and never pops when empty
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count <= QCNT_BITS'(QUEUE_DEPTH)) && !(q_pop && q_empty))
        else $error("command queue overflow or underflow");

endmodule

`default_nettype wire

/* rtl/fims_front.sv */
`default_nettype none

module fims_front (
    input  fims_pkg::t_cfg  i_cfg,
    fims_pix_if.sink        i_pix,
    input  logic            i_q_full,
    output logic            o_push,
    output fims_pkg::t_cmd  o_cmd
);
    import fims_pkg::*;

    logic [SIZE_BITS-1:0] eff_w;
    logic [SIZE_BITS-1:0] eff_h;
    logic [CHAN_W-1:0]    eff_max;
    logic [SIZE_BITS-1:0] row_s;
    logic [SIZE_BITS-1:0] col_s;
    logic                 in_img;
    logic                 keep;
    logic [PIX_BITS-1:0]  clamped;
    logic [CHAN_W-1:0]    chan_in [NUM_CHAN];

    // Effective geometry and intensity limit
    assign eff_w   = (int'(i_cfg.width) > MAX_WIDTH) ? SIZE_BITS'(MAX_WIDTH) : i_cfg.width;
    assign eff_h   = (int'(i_cfg.height) > MAX_HEIGHT) ? SIZE_BITS'(MAX_HEIGHT) : i_cfg.height;
    assign eff_max = (i_cfg.max_intensity > CHAN_MAX) ? CHAN_MAX : i_cfg.max_intensity;

    assign row_s  = SIZE_BITS'(i_pix.row);
    assign col_s  = SIZE_BITS'(i_pix.column);
    assign in_img = (row_s < eff_h) && (col_s < eff_w);

    // Clamp the write channels, packed {red, green, blue}
    assign chan_in[2] = i_pix.red;
    assign chan_in[1] = i_pix.green;
    assign chan_in[0] = i_pix.blue;

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            clamped[k*CHANNEL_BITS +: CHANNEL_BITS] =
                CHANNEL_BITS'((chan_in[k] > eff_max) ? eff_max : chan_in[k]);
        end
    end

    // Classify: drop out-of-range writes, empty sweeps and unused codes
    always_comb begin
        o_cmd        = '0;
        o_cmd.addr   = in_img ? mk_addr(row_s, col_s) : '0;
        o_cmd.in_img = in_img;
        o_cmd.pix    = clamped;
        o_cmd.maxv   = eff_max;
        keep         = 1'b0;
        unique case (i_pix.func)
            FUNC_WRITE: begin
                o_cmd.op = OP_WRITE;
                keep     = in_img;
            end
            FUNC_READ: begin
                o_cmd.op = OP_READ;
                keep     = 1'b1;
            end
            FUNC_INVERT: begin
                o_cmd.op    = OP_INVERT;
                o_cmd.lim_o = eff_h;
                o_cmd.lim_i = eff_w;
                keep        = (eff_h != '0) && (eff_w != '0);
            end
            FUNC_MROWS: begin
                o_cmd.op    = OP_MROWS;
                o_cmd.lim_o = eff_h >> 1;
                o_cmd.lim_i = eff_w;
                o_cmd.far   = eff_h - SIZE_BITS'(1);
                keep        = ((eff_h >> 1) != '0) && (eff_w != '0);
            end
            FUNC_MCOLS: begin
                o_cmd.op    = OP_MCOLS;
                o_cmd.lim_o = eff_w >> 1;
                o_cmd.lim_i = eff_h;
                o_cmd.far   = eff_w - SIZE_BITS'(1);
                keep        = ((eff_w >> 1) != '0) && (eff_h != '0);
            end
            default: begin
                o_cmd.op = OP_WRITE;
                keep     = 1'b0;
            end
        endcase
    end

    assign i_pix.ready = !i_q_full;
    assign o_push      = i_pix.valid && !i_q_full && keep;

endmodule

`default_nettype wire

/* rtl/fims_cmd_fifo.sv */
`default_nettype none

module fims_cmd_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  fims_pkg::t_cmd                i_cmd,
    input  logic                          i_pop,
    output fims_pkg::t_cmd                o_cmd,
    output logic                          o_empty,
    output logic                          o_full,
    output logic [fims_pkg::QCNT_BITS-1:0] o_count
);
    import fims_pkg::*;

    t_cmd                 r_slot [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr;
    logic [QPTR_BITS-1:0] r_rptr;
    logic [QCNT_BITS-1:0] r_count;

    assign o_cmd   = r_slot[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_count = r_count;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/fims_back.sv */
`default_nettype none

module fims_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  fims_pkg::t_cmd i_q_cmd,
    output logic           o_pop,
    fims_res_if.source     o_res
);
    import fims_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INV   = 3'd1;
    localparam logic [2:0] S_MRD_A = 3'd2;
    localparam logic [2:0] S_MRD_B = 3'd3;
    localparam logic [2:0] S_MWR_A = 3'd4;
    localparam logic [2:0] S_MWR_B = 3'd5;

    logic [PIX_BITS-1:0]  r_store [STORE_DEPTH];
    logic [PIX_BITS-1:0]  r_rdata;
    logic [PIX_BITS-1:0]  r_hold;

    logic [2:0]           r_state;
    logic [SIZE_BITS-1:0] r_ci;
    logic [SIZE_BITS-1:0] r_cj;
    logic [SIZE_BITS-1:0] r_lim_o;
    logic [SIZE_BITS-1:0] r_lim_i;
    logic [SIZE_BITS-1:0] r_far;
    logic [CHAN_W-1:0]    r_max;
    logic                 r_cols;

    logic                 r_iw_pend;
    logic [ADDR_BITS-1:0] r_iw_addr;
    logic                 r_rd_pend;
    logic                 r_rd_inside;
    logic                 r_out_valid;
    logic [PIX_BITS-1:0]  r_out_pix;
    logic                 r_out_in_range;

    logic                 can_go;
    logic                 out_free;
    logic                 last_i;
    logic                 last_j;
    logic                 step;
    logic [SIZE_BITS-1:0] far_i;
    logic [ADDR_BITS-1:0] addr_a;
    logic [ADDR_BITS-1:0] addr_b;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [PIX_BITS-1:0]  wr_data;

    function automatic logic [PIX_BITS-1:0] inv_pix(input logic [PIX_BITS-1:0] p,
                                                    input logic [CHAN_W-1:0] m);
        logic [PIX_BITS-1:0] q;
        for (int k = 0; k < NUM_CHAN; k++) begin
            q[k*CHANNEL_BITS +: CHANNEL_BITS] =
                CHANNEL_BITS'(m - CHAN_W'(p[k*CHANNEL_BITS +: CHANNEL_BITS]));
        end
        return q;
    endfunction

    // Dispatch from the queue; reads wait for a free output slot
    assign can_go   = (r_state == S_IDLE) && !i_q_empty && !r_iw_pend;
    assign out_free = !r_rd_pend && (!r_out_valid || o_res.ready);
    assign o_pop    = can_go && ((i_q_cmd.op != OP_READ) || out_free);

    // Sweep addressing: a is the near pixel, b its mirror partner
    assign far_i  = r_far - r_ci;
    assign addr_a = r_cols ? mk_addr(r_cj, r_ci) : mk_addr(r_ci, r_cj);
    assign addr_b = r_cols ? mk_addr(r_cj, far_i) : mk_addr(far_i, r_cj);
    assign last_j = (r_cj == r_lim_i - SIZE_BITS'(1));
    assign last_i = (r_ci == r_lim_o - SIZE_BITS'(1));
    assign step   = (r_state == S_INV) || (r_state == S_MWR_B);

    // Store port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = addr_a;
        wr_en   = 1'b0;
        wr_addr = addr_a;
        wr_data = r_rdata;
        if (r_iw_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_iw_addr;
            wr_data = inv_pix(r_rdata, r_max);
        end
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && (i_q_cmd.op == OP_WRITE)) begin
                    wr_en   = 1'b1;
                    wr_addr = i_q_cmd.addr;
                    wr_data = i_q_cmd.pix;
                end
                if (o_pop && (i_q_cmd.op == OP_READ) && i_q_cmd.in_img) begin
                    rd_en   = 1'b1;
                    rd_addr = i_q_cmd.addr;
                end
            end
            S_INV, S_MRD_A: begin
                rd_en = 1'b1;
            end
            S_MRD_B: begin
                rd_en   = 1'b1;
                rd_addr = addr_b;
            end
            S_MWR_A: begin
                wr_en = 1'b1;
            end
            S_MWR_B: begin
                wr_en   = 1'b1;
                wr_addr = addr_b;
                wr_data = r_hold;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Frame store, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_store[rd_addr];
        end
    end

    // Sweep payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_MRD_B) begin
            r_hold <= r_rdata;
        end
        if (r_state == S_INV) begin
            r_iw_addr <= addr_a;
        end
        if (o_pop) begin
            r_lim_o <= i_q_cmd.lim_o;
            r_lim_i <= i_q_cmd.lim_i;
            r_far   <= i_q_cmd.far;
            r_max   <= i_q_cmd.maxv;
            r_cols  <= (i_q_cmd.op == OP_MCOLS);
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ci      <= '0;
            r_cj      <= '0;
            r_iw_pend <= 1'b0;
        end else begin
            r_iw_pend <= (r_state == S_INV);
            unique case (r_state)
                S_IDLE: begin
                    r_ci <= '0;
                    r_cj <= '0;
                    if (o_pop && (i_q_cmd.op == OP_INVERT)) begin
                        r_state <= S_INV;
                    end else if (o_pop && ((i_q_cmd.op == OP_MROWS) ||
                                           (i_q_cmd.op == OP_MCOLS))) begin
                        r_state <= S_MRD_A;
                    end
                end
                S_MRD_A: r_state <= S_MRD_B;
                S_MRD_B: r_state <= S_MWR_A;
                S_MWR_A: r_state <= S_MWR_B;
                S_INV, S_MWR_B: begin
                    if (r_state == S_MWR_B) begin
                        r_state <= S_MRD_A;
                    end
                    if (step && last_j) begin
                        r_cj <= '0;
                        r_ci <= r_ci + 1'b1;
                        if (last_i) begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_cj <= r_cj + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_out_pix      <= r_rd_inside ? r_rdata : '0;
            r_out_in_range <= r_rd_inside;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_rd_inside <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= o_pop && (i_q_cmd.op == OP_READ);
            if (o_pop) begin
                r_rd_inside <= i_q_cmd.in_img;
            end
            if (r_rd_pend) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.red_out   = CHAN_W'(r_out_pix[2*CHANNEL_BITS +: CHANNEL_BITS]);
    assign o_res.green_out = CHAN_W'(r_out_pix[CHANNEL_BITS +: CHANNEL_BITS]);
    assign o_res.blue_out  = CHAN_W'(r_out_pix[0 +: CHANNEL_BITS]);
    assign o_res.in_range  = r_out_in_range;

endmodule

`default_nettype wire
